// ----- hw/rtl/cby_pkg.sv -----
// Shared constants, control word type and microcode table for the Bezier y-for-x core.
// No dependencies; every other file imports this package.
package cby_pkg;

  localparam int TBits     = 24;
  localparam int XFracBits = 16;
  localparam int XW        = 32;
  localparam int YW        = 16;
  localparam int TW        = TBits + 1;
  localparam int HalvW     = $clog2(TBits + 1);
  localparam int QuoW      = XFracBits + 1;
  localparam int RemW      = XW + 1;
  localparam int DivCntW   = $clog2(XFracBits + 1);
  localparam int CfgIdxW   = 3;
  localparam int PcW       = 5;

  localparam logic [CfgIdxW-1:0] CfgAX = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAY = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBX = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBY = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCX = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCY = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDX = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgDY = 3'd7;

  localparam logic [XW-1:0] ResetAX = 32'd0;
  localparam logic [YW-1:0] ResetAY = 16'd0;
  localparam logic [XW-1:0] ResetBX = 32'd0;
  localparam logic [YW-1:0] ResetBY = 16'd0;
  localparam logic [XW-1:0] ResetCX = 32'd65536;
  localparam logic [YW-1:0] ResetCY = 16'd65535;
  localparam logic [XW-1:0] ResetDX = 32'd65536;
  localparam logic [YW-1:0] ResetDY = 16'd65535;

  // sequencer operations
  localparam logic [2:0] OpNop  = 3'd0;
  localparam logic [2:0] OpWait = 3'd1;
  localparam logic [2:0] OpDiv  = 3'd2;
  localparam logic [2:0] OpChk  = 3'd3;
  localparam logic [2:0] OpEmit = 3'd4;

  // lerp operand selects
  localparam logic [3:0] SelP0 = 4'd0;
  localparam logic [3:0] SelP1 = 4'd1;
  localparam logic [3:0] SelP2 = 4'd2;
  localparam logic [3:0] SelP3 = 4'd3;
  localparam logic [3:0] SelQ0 = 4'd4;
  localparam logic [3:0] SelQ1 = 4'd5;
  localparam logic [3:0] SelQ2 = 4'd6;
  localparam logic [3:0] SelR0 = 4'd7;
  localparam logic [3:0] SelR1 = 4'd8;

  // lerp write-back destinations
  localparam logic [2:0] DstQ0  = 3'd0;
  localparam logic [2:0] DstQ1  = 3'd1;
  localparam logic [2:0] DstQ2  = 3'd2;
  localparam logic [2:0] DstR0  = 3'd3;
  localparam logic [2:0] DstR1  = 3'd4;
  localparam logic [2:0] DstRes = 3'd5;

  // program addresses
  localparam logic [PcW-1:0] PcWait  = 5'd0;
  localparam logic [PcW-1:0] PcDiv   = 5'd1;
  localparam logic [PcW-1:0] PcXEval = 5'd2;
  localparam logic [PcW-1:0] PcChk   = 5'd10;
  localparam logic [PcW-1:0] PcYEval = 5'd11;
  localparam logic [PcW-1:0] PcEmit  = 5'd19;

  typedef struct packed {
    logic [2:0]     op;
    logic           mul_en;
    logic [3:0]     sel_a;
    logic [3:0]     sel_b;
    logic           wb_en;
    logic [2:0]     dst;
    logic           coord_y;
    logic [PcW-1:0] jump;
  } ctrl_t;

  // one de Casteljau evaluation, multiply and write-back overlapped
  function automatic ctrl_t cby_eval_word(input logic [2:0] k, input logic coord_y);
    ctrl_t w;
    w         = '0;
    w.op      = OpNop;
    w.coord_y = coord_y;
    case (k)
      3'd0: begin
        w.mul_en = 1'b1; w.sel_a = SelP0; w.sel_b = SelP1;
      end
      3'd1: begin
        w.mul_en = 1'b1; w.sel_a = SelP1; w.sel_b = SelP2;
        w.wb_en  = 1'b1; w.dst   = DstQ0;
      end
      3'd2: begin
        w.mul_en = 1'b1; w.sel_a = SelP2; w.sel_b = SelP3;
        w.wb_en  = 1'b1; w.dst   = DstQ1;
      end
      3'd3: begin
        w.mul_en = 1'b1; w.sel_a = SelQ0; w.sel_b = SelQ1;
        w.wb_en  = 1'b1; w.dst   = DstQ2;
      end
      3'd4: begin
        w.mul_en = 1'b1; w.sel_a = SelQ1; w.sel_b = SelQ2;
        w.wb_en  = 1'b1; w.dst   = DstR0;
      end
      3'd5: begin
        w.wb_en = 1'b1; w.dst = DstR1;
      end
      3'd6: begin
        w.mul_en = 1'b1; w.sel_a = SelR0; w.sel_b = SelR1;
      end
      3'd7: begin
        w.wb_en = 1'b1; w.dst = DstRes;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic ctrl_t cby_uop(input logic [PcW-1:0] pc);
    ctrl_t w;
    logic [PcW-1:0] kx;
    logic [PcW-1:0] ky;
    w  = '0;
    kx = pc - PcXEval;
    ky = pc - PcYEval;
    case (pc) inside
      PcWait: w.op = OpWait;
      PcDiv: begin
        w.op   = OpDiv;
        w.jump = PcYEval;
      end
      [PcXEval:PcChk-5'd1]:  w = cby_eval_word(kx[2:0], 1'b0);
      PcChk: begin
        w.op   = OpChk;
        w.jump = PcXEval;
      end
      [PcYEval:PcEmit-5'd1]: w = cby_eval_word(ky[2:0], 1'b1);
      PcEmit: begin
        w.op   = OpEmit;
        w.jump = PcWait;
      end
      default: w.op = OpNop;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/cby_if.sv -----
// Valid/ready channel interfaces: target request, result request and register writes.
// Depends on cby_pkg.
interface cby_in_if;
  import cby_pkg::*;
  logic          valid;
  logic          ready;
  logic [XW-1:0] target_x;
  modport source (output valid, output target_x, input ready);
  modport sink (input valid, input target_x, output ready);
endinterface

interface cby_out_if;
  import cby_pkg::*;
  logic          valid;
  logic          ready;
  logic [YW-1:0] curve_y;
  logic          converged;
  modport source (output valid, output curve_y, output converged, input ready);
  modport sink (input valid, input curve_y, input converged, output ready);
endinterface

interface cby_cfg_if;
  import cby_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [XW-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cubic_bezier_y_for_x_core.sv -----
// Cubic Bezier y-for-x lookup: microcoded bisection over one shared lerp multiplier.
// Sequence: accept, a 17-bit restoring divide for the tolerance, x evaluation and a bisection check
// (up to 25 checks), y evaluation, emit; when end x is below one sample, the divide jumps to y at t = 1/2.
// One request at a time, taken only in the wait step; every lerp uses the single 32x25 multiplier.
// Reset: asynchronous active low; sequencer idles, result slot empties, control points take reset values.
// Depends on cby_pkg and cby_if.
module cubic_bezier_y_for_x_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  cby_in_if.sink           in_i,
  cby_out_if.source        out_o,
  cby_cfg_if.sink          cfg_i
);
  import cby_pkg::*;

  localparam logic [TW-1:0]      THalf     = TW'(1) << (TBits - 1);
  localparam logic [TW-1:0]      TOne      = TW'(1) << TBits;
  localparam logic [XW-1:0]      OneSample = XW'(1) << XFracBits;
  localparam logic [RemW-1:0]    RemInit   = RemW'(1) << XFracBits;
  localparam logic [HalvW-1:0]   HalvMax   = HalvW'(TBits);
  localparam logic [DivCntW-1:0] DivLast   = DivCntW'(XFracBits);

  logic [XW-1:0] ax_q, bx_q, cx_q, dx_q;
  logic [YW-1:0] ay_q, by_q, cy_q, dy_q;

  logic [PcW-1:0]     pc_q, pc_d;
  logic [XW-1:0]      target_q;
  logic [TW-1:0]      t_q, lo_q, hi_q;
  logic [HalvW-1:0]   halv_q;
  logic               conv_q;
  logic [RemW-1:0]    rem_q;
  logic [QuoW-1:0]    quo_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [XW-1:0]      prod_q, base_q;
  logic               neg_q;
  logic [XW-1:0]      q0_q, q1_q, q2_q, r0_q, r1_q, res_q;
  logic               out_valid_q;
  logic [YW-1:0]      out_y_q;
  logic               out_conv_q;

  ctrl_t               uop;
  logic [XW-1:0]       p0, p1, p2, p3;
  logic [XW-1:0]       op_a, op_b, span;
  logic [XW+TW-1:0]    mult;
  logic [XW-1:0]       wb_val;
  logic                in_acc, slot_free, small_d;
  logic                gt, hit;
  logic [XW-1:0]       adiff;
  logic [TW-1:0]       lo_d, hi_d;
  logic [TW:0]         tsum;
  logic                rem_ge;
  logic [RemW-1:0]     rem_sub;

  assign uop = cby_uop(pc_q);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (uop.op == OpWait);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.curve_y   = out_y_q;
  assign out_o.converged = out_conv_q;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign small_d     = dx_q < OneSample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= ResetAX; ay_q <= ResetAY;
      bx_q <= ResetBX; by_q <= ResetBY;
      cx_q <= ResetCX; cy_q <= ResetCY;
      dx_q <= ResetDX; dy_q <= ResetDY;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgAX: ax_q <= cfg_i.data;
        CfgAY: ay_q <= cfg_i.data[YW-1:0];
        CfgBX: bx_q <= cfg_i.data;
        CfgBY: by_q <= cfg_i.data[YW-1:0];
        CfgCX: cx_q <= cfg_i.data;
        CfgCY: cy_q <= cfg_i.data[YW-1:0];
        CfgDX: dx_q <= cfg_i.data;
        CfgDY: dy_q <= cfg_i.data[YW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p0 = uop.coord_y ? XW'(ay_q) : ax_q;
    p1 = uop.coord_y ? XW'(by_q) : bx_q;
    p2 = uop.coord_y ? XW'(cy_q) : cx_q;
    p3 = uop.coord_y ? XW'(dy_q) : dx_q;
  end

  always_comb begin
    case (uop.sel_a)
      SelP0:   op_a = p0;
      SelP1:   op_a = p1;
      SelP2:   op_a = p2;
      SelQ0:   op_a = q0_q;
      SelQ1:   op_a = q1_q;
      SelR0:   op_a = r0_q;
      default: op_a = '0;
    endcase
    case (uop.sel_b)
      SelP1:   op_b = p1;
      SelP2:   op_b = p2;
      SelP3:   op_b = p3;
      SelQ1:   op_b = q1_q;
      SelQ2:   op_b = q2_q;
      SelR1:   op_b = r1_q;
      default: op_b = '0;
    endcase
  end

  assign span   = (op_b >= op_a) ? (op_b - op_a) : (op_a - op_b);
  assign mult   = XW'(span) * TW'(t_q) + (XW + TW)'(0);
  assign wb_val = neg_q ? (base_q - prod_q) : (base_q + prod_q);

  always_ff @(posedge clk_i) begin
    if (uop.mul_en) begin
      prod_q <= mult[TBits +: XW];
      base_q <= op_a;
      neg_q  <= op_b < op_a;
    end
    if (uop.wb_en) begin
      case (uop.dst)
        DstQ0:   q0_q  <= wb_val;
        DstQ1:   q1_q  <= wb_val;
        DstQ2:   q2_q  <= wb_val;
        DstR0:   r0_q  <= wb_val;
        DstR1:   r1_q  <= wb_val;
        DstRes:  res_q <= wb_val;
        default: ;
      endcase
    end
  end

  // restoring divider for the tolerance, one quotient bit a step
  assign rem_ge  = rem_q >= {1'b0, dx_q};
  assign rem_sub = rem_ge ? (rem_q - {1'b0, dx_q}) : rem_q;

  // bisection decision
  assign gt    = target_q > res_q;
  assign adiff = gt ? (target_q - res_q) : (res_q - target_q);
  assign hit   = adiff <= XW'(quo_q);
  assign lo_d  = gt ? t_q : lo_q;
  assign hi_d  = gt ? hi_q : t_q;
  assign tsum  = {1'b0, lo_d} + {1'b0, hi_d};

  always_comb begin
    pc_d = pc_q;
    case (uop.op)
      OpWait:  if (in_acc) pc_d = pc_q + 1'b1;
      OpDiv: begin
        if (small_d) pc_d = uop.jump;
        else if (dcnt_q == DivLast) pc_d = pc_q + 1'b1;
      end
      OpChk: begin
        if (hit || (halv_q == HalvMax)) pc_d = pc_q + 1'b1;
        else pc_d = uop.jump;
      end
      OpEmit:  if (slot_free) pc_d = uop.jump;
      default: pc_d = pc_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if ((uop.op == OpEmit) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uop.op)
      OpWait: begin
        if (in_acc) begin
          target_q <= in_i.target_x;
          t_q      <= THalf;
          lo_q     <= '0;
          hi_q     <= TOne;
          halv_q   <= '0;
          rem_q    <= RemInit;
          quo_q    <= '0;
          dcnt_q   <= '0;
        end
      end
      OpDiv: begin
        if (small_d) begin
          conv_q <= 1'b1;
        end else begin
          quo_q  <= {quo_q[QuoW-2:0], rem_ge};
          rem_q  <= {rem_sub[RemW-2:0], 1'b0};
          dcnt_q <= dcnt_q + 1'b1;
        end
      end
      OpChk: begin
        if (hit) begin
          conv_q <= 1'b1;
        end else if (halv_q == HalvMax) begin
          conv_q <= 1'b0;
        end else begin
          lo_q   <= lo_d;
          hi_q   <= hi_d;
          t_q    <= tsum[TW:1];
          halv_q <= halv_q + 1'b1;
        end
      end
      OpEmit: begin
        if (slot_free) begin
          out_y_q    <= res_q[YW-1:0];
          out_conv_q <= conv_q;
        end
      end
      default: ;
    endcase
  end

  a_halv_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcChk) |-> (halv_q <= HalvMax))
    else $error("halving count beyond cap");

  a_t_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcChk) |-> ((t_q >= lo_q) && (t_q <= hi_q)))
    else $error("bisection point outside its bounds");

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (pc_q == PcDiv))
    else $error("accepted request did not start the divider");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == PcEmit))
    else $error("result raised outside the emit step");

endmodule

// ----- bench/tb_cubic_bezier_y_for_x_core.sv -----
// Self-checking bench for cubic_bezier_y_for_x_core: directed table, then random curves and targets.
// Lookups are predicted by a bit-exact bisection model or the table row; results checked in order.
// Depends on cby_pkg, cby_if and the core.
module tb_cubic_bezier_y_for_x_core;
  import cby_pkg::*;

  typedef struct packed {
    logic [YW-1:0] curve_y;
    logic          converged;
  } lookup_res_t;

  typedef struct packed {
    logic               is_write;
    logic [CfgIdxW-1:0] index;
    logic [XW-1:0]      value;
    logic               literal;
    lookup_res_t        want;
  } dir_row_t;

  localparam int DirRows   = 41;
  localparam int RandItems = 1350;
  localparam int TailWait  = 260;

  localparam dir_row_t DirTable [DirRows] = '{
    '{1'b0, CfgAX, 32'h0000_0000, 1'b1, '{16'd32767, 1'b1}},
    '{1'b0, CfgAX, 32'd98304,     1'b1, '{16'd32767, 1'b1}},
    '{1'b0, CfgAX, 32'd32768,     1'b1, '{16'd32767, 1'b1}},
    '{1'b0, CfgAX, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'd200000,    1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgDX, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'hFFFF_FFFF, 1'b1, '{16'd32767, 1'b1}},
    '{1'b0, CfgAX, 32'h0000_0000, 1'b1, '{16'd32767, 1'b1}},
    '{1'b1, CfgDX, 32'd65535,     1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h1234_5678, 1'b1, '{16'd32767, 1'b1}},
    '{1'b1, CfgAY, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgBY, 32'h0000_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h8000_0000, 1'b1, '{16'd65535, 1'b1}},
    '{1'b1, CfgDX, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h7FFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgAY, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgBY, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgCY, 32'hFFFF_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgDY, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgAX, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgBX, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgCX, 32'hFFFF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'hFFFF_FFFF, 1'b1, '{16'd0, 1'b1}},
    '{1'b0, CfgAX, 32'h0000_0000, 1'b1, '{16'd0, 1'b0}},
    '{1'b1, CfgCX, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgBY, 32'h0000_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgCY, 32'h0000_1234, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h8000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'hC000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgAX, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgBX, 32'h0040_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgCX, 32'h00C0_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgDX, 32'h0100_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgAY, 32'h0000_0100, 1'b0, '{16'd0, 1'b0}},
    '{1'b1, CfgDY, 32'h0000_FF00, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h0000_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h0080_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h0100_0000, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h00FF_FFFF, 1'b0, '{16'd0, 1'b0}},
    '{1'b0, CfgAX, 32'h5555_5555, 1'b0, '{16'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  cby_in_if  in_ch ();
  cby_out_if out_ch ();
  cby_cfg_if cfg_ch ();

  cubic_bezier_y_for_x_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  logic [XW-1:0] ctrl_x [4];
  logic [YW-1:0] ctrl_y [4];
  lookup_res_t   due_results [$];
  int            bad_count;
  bit            calm;
  int            stall_left;
  logic [XW-1:0] tgt_lo;
  logic [XW-1:0] tgt_hi;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("cubic_bezier_y_for_x_core: mismatch");
    $finish;
  end

  function automatic logic [63:0] lerp_trunc(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] t);
    if (b >= a) begin
      return a + (((b - a) * t) >> TBits);
    end
    return a - (((a - b) * t) >> TBits);
  endfunction

  function automatic logic [63:0] casteljau(input logic [63:0] p0, input logic [63:0] p1,
                                            input logic [63:0] p2, input logic [63:0] p3,
                                            input logic [63:0] t);
    logic [63:0] q0, q1, q2, r0, r1;
    q0 = lerp_trunc(p0, p1, t);
    q1 = lerp_trunc(p1, p2, t);
    q2 = lerp_trunc(p2, p3, t);
    r0 = lerp_trunc(q0, q1, t);
    r1 = lerp_trunc(q1, q2, t);
    return lerp_trunc(r0, r1, t);
  endfunction

  function automatic lookup_res_t bisect_lookup(input logic [XW-1:0] target);
    logic [63:0] tgt, lo, hi, t, tol, x, diff;
    int          halvings;
    bit          stop;
    lookup_res_t res;
    tgt           = {32'd0, target};
    lo            = 64'd0;
    hi            = 64'd1 << TBits;
    t             = 64'd1 << (TBits - 1);
    res.converged = 1'b0;
    if ({32'd0, ctrl_x[3]} < (64'd1 << XFracBits)) begin
      res.curve_y   = YW'(casteljau(64'(ctrl_y[0]), 64'(ctrl_y[1]),
                                    64'(ctrl_y[2]), 64'(ctrl_y[3]), t));
      res.converged = 1'b1;
      return res;
    end
    tol      = (64'd1 << (2 * XFracBits)) / {32'd0, ctrl_x[3]};
    halvings = 0;
    stop     = 1'b0;
    while (!stop) begin
      x    = casteljau(64'(ctrl_x[0]), 64'(ctrl_x[1]), 64'(ctrl_x[2]), 64'(ctrl_x[3]), t)
             & 64'hFFFF_FFFF;
      diff = (tgt > x) ? tgt - x : x - tgt;
      if (diff <= tol) begin
        res.converged = 1'b1;
        stop          = 1'b1;
      end else if (halvings >= TBits) begin
        stop = 1'b1;
      end else begin
        if (tgt > x) begin
          lo = t;
        end else begin
          hi = t;
        end
        t = (lo + hi) >> 1;
        halvings++;
      end
    end
    res.curve_y = YW'(casteljau(64'(ctrl_y[0]), 64'(ctrl_y[1]),
                                64'(ctrl_y[2]), 64'(ctrl_y[3]), t));
    return res;
  endfunction

  function automatic void store_reg(input logic [CfgIdxW-1:0] idx, input logic [XW-1:0] data);
    case (idx)
      CfgAX: ctrl_x[0] = data;
      CfgAY: ctrl_y[0] = data[YW-1:0];
      CfgBX: ctrl_x[1] = data;
      CfgBY: ctrl_y[1] = data[YW-1:0];
      CfgCX: ctrl_x[2] = data;
      CfgCY: ctrl_y[2] = data[YW-1:0];
      CfgDX: ctrl_x[3] = data;
      CfgDY: ctrl_y[3] = data[YW-1:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [XW-1:0] pick_between(input logic [XW-1:0] lo, input logic [XW-1:0] hi);
    logic [XW:0] span;
    span = {1'b0, hi} - {1'b0, lo} + 33'd1;
    if (span[XW]) begin
      return $urandom;
    end
    return lo + ($urandom % span[XW-1:0]);
  endfunction

  function automatic logic [XW-1:0] pick_x_edge();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  function automatic logic [YW-1:0] pick_y();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return '1;
    end
    return YW'($urandom);
  endfunction

  function automatic logic [XW-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return pick_between(tgt_lo, tgt_hi);
    end
    if (r < 88) begin
      return tgt_lo;
    end
    if (r < 91) begin
      return tgt_hi;
    end
    return $urandom;
  endfunction

  // hold the request line high or drop it for a random gap
  task automatic space_out(input bit cfg_side);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (cfg_side) begin
        cfg_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [XW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    store_reg(idx, data);
    space_out(1'b1);
  endtask

  task automatic send_lookup(input logic [XW-1:0] target, input bit literal,
                             input lookup_res_t want);
    in_ch.valid    <= 1'b1;
    in_ch.target_x <= target;
    do @(posedge clk); while (!in_ch.ready);
    due_results.push_back(literal ? want : bisect_lookup(target));
    space_out(1'b0);
  endtask

  task automatic program_curve();
    int            mode;
    int            k;
    int            i;
    logic [XW-1:0] v [8];
    logic [XW-1:0] ax, bx, cx, dx;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      k  = $urandom_range(16, 31);
      dx = (32'd1 << k) | ($urandom & ((32'd1 << k) - 32'd1));
      ax = ($urandom_range(0, 3) == 0) ? 32'd0 : pick_between(32'd0, dx >> 2);
      bx = pick_between(ax, dx);
      cx = pick_between(bx, dx);
    end else if (mode == 6) begin
      ax = $urandom;
      bx = $urandom;
      cx = $urandom;
      dx = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(0, 65535));
    end else if (mode == 8) begin
      ax = pick_x_edge();
      bx = pick_x_edge();
      cx = pick_x_edge();
      dx = pick_x_edge();
    end else begin
      ax = $urandom;
      bx = $urandom;
      cx = $urandom;
      dx = $urandom;
    end
    v[CfgAX] = ax;
    v[CfgBX] = bx;
    v[CfgCX] = cx;
    v[CfgDX] = dx;
    v[CfgAY] = {16'($urandom), pick_y()};
    v[CfgBY] = {16'($urandom), pick_y()};
    v[CfgCY] = {16'($urandom), pick_y()};
    v[CfgDY] = {16'($urandom), pick_y()};
    for (i = 0; i < 8; i++) begin
      if (mode != 9 || $urandom_range(0, 1) == 1) begin
        write_reg(CfgIdxW'(i), v[i]);
      end
    end
    tgt_lo = (ctrl_x[0] < ctrl_x[3]) ? ctrl_x[0] : ctrl_x[3];
    tgt_hi = (ctrl_x[0] < ctrl_x[3]) ? ctrl_x[3] : ctrl_x[0];
  endtask

  initial begin
    lookup_res_t got;
    lookup_res_t exp_res;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.curve_y   = out_ch.curve_y;
        got.converged = out_ch.converged;
        if (due_results.size() == 0) begin
          $error("curve_y: no lookup pending, actual %0d", got.curve_y);
          bad_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (got.curve_y !== exp_res.curve_y) begin
            $error("curve_y: expected %0d, actual %0d", exp_res.curve_y, got.curve_y);
            bad_count++;
          end
          if (got.converged !== exp_res.converged) begin
            $error("converged: expected %0d, actual %0d", exp_res.converged, got.converged);
            bad_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int  sent;
    int  n;
    bit  prev_write;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.target_x = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CfgAX;
    cfg_ch.data    = '0;
    bad_count      = 0;
    calm           = 1'b0;
    ctrl_x[0]      = ResetAX;
    ctrl_y[0]      = ResetAY;
    ctrl_x[1]      = ResetBX;
    ctrl_y[1]      = ResetBY;
    ctrl_x[2]      = ResetCX;
    ctrl_y[2]      = ResetCY;
    ctrl_x[3]      = ResetDX;
    ctrl_y[3]      = ResetDY;
    tgt_lo         = '0;
    tgt_hi         = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    prev_write = 1'b0;
    foreach (DirTable[i]) begin
      if (DirTable[i].is_write != prev_write) begin
        quiesce();
      end
      prev_write = DirTable[i].is_write;
      if (DirTable[i].is_write) begin
        write_reg(DirTable[i].index, DirTable[i].value);
      end else begin
        send_lookup(DirTable[i].value, DirTable[i].literal, DirTable[i].want);
      end
    end

    sent = 0;
    while (sent < RandItems) begin
      calm = 1'b0;
      quiesce();
      program_curve();
      quiesce();
      calm = ($urandom_range(0, 4) == 0);
      n    = $urandom_range(15, 60);
      repeat (n) begin
        if ($urandom_range(0, 99) == 0) begin
          quiesce();
        end
        send_lookup(pick_target(), 1'b0, '0);
        sent++;
      end
    end

    calm = 1'b0;
    quiesce();
    repeat (TailWait) @(posedge clk);
    if (bad_count == 0 && due_results.size() == 0) begin
      $display("cubic_bezier_y_for_x_core: match");
    end else begin
      $display("cubic_bezier_y_for_x_core: mismatch");
    end
    $finish;
  end

endmodule
